// ----- rtl/core/sjfq_pkg.sv -----
// ----------------------------------------------------------------------------
// sjfq_pkg : shortest-job-first queue shared types and constants
// Beat structs, status codes and the cell control bundle.
// ----------------------------------------------------------------------------
package sjfq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int ID_W      = 8;
	localparam int BURST_W   = 16;
	localparam int OCC_W     = 4;
	localparam int STATUS_W  = 2;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic               mode;
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst_time;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     out_id;
		logic [BURST_W-1:0]  out_burst;
		logic [OCC_W-1:0]    occupancy;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
	} entry_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t new_job;
	} cell_ctl_t;

endpackage

// ----- rtl/core/shortest_job_first_queue.sv -----
// ----------------------------------------------------------------------------
// shortest_job_first_queue : bounded queue returning the shortest job first
// A row of DEPTH cells kept sorted by burst time, ties in arrival order.
// ----------------------------------------------------------------------------
// Usage
//   Command beat: raise start with item (mode, job_id, burst_time); it is
//   taken at the rising edge where start is high and busy is low.
//   mode 0 enqueues the job, mode 1 dequeues the job with the smallest
//   burst time (earliest arrival on a tie).
//   Result beat: done pulses for exactly one cycle, the cycle after the
//   command is taken, with status, out_id, out_burst and occupancy. The
//   receiver cannot stall; it must sample the result while done is high.
//   The result is registered; busy is high during the result cycle, so
//   a new command is not taken until the last one's result is out.
//   Every cell compares its burst with the incoming one in parallel, so all
//   cells update together on an insert or a removal whatever DEPTH is.
//   Full queue on enqueue: drop the job, report full. Empty queue on
//   dequeue: report empty with zero fields.
//   Reset: the job count clears, so the queue is empty at once; cell
//   contents are left as they are and never read before being written.
// ----------------------------------------------------------------------------
module shortest_job_first_queue #(
	parameter int DEPTH = sjfq_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sjfq_pkg::item_t   item,
	output logic              done,
	output sjfq_pkg::result_t result
);
	import sjfq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             busy_q;
	result_t          result_q;

	logic      accept;
	logic      is_full;
	logic      is_empty;
	logic      do_enq;
	logic      do_deq;
	cell_ctl_t ctl;

	logic   used [DEPTH];
	logic   gt   [DEPTH];
	entry_t job  [DEPTH];

	assign accept   = start && !busy_q;
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign do_enq   = accept && (item.mode == MODE_ENQ) && !is_full;
	assign do_deq   = accept && (item.mode == MODE_DEQ) && !is_empty;

	assign ctl.enq             = do_enq;
	assign ctl.deq             = do_deq;
	assign ctl.new_job.id      = item.job_id;
	assign ctl.new_job.burst   = item.burst_time;

	// Row of cells: cell 0 always holds the shortest job.
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		assign used[gi] = (count_q > CNT_W'(gi));

		if (gi == 0) begin : g_first
			sjfq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.used      (used[gi]),
				.left_gt   (1'b0),
				.left_job  ('0),
				.right_job (job[gi+1]),
				.gt        (gt[gi]),
				.job       (job[gi])
			);
		end else if (gi == DEPTH - 1) begin : g_last
			sjfq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.used      (used[gi]),
				.left_gt   (gt[gi-1]),
				.left_job  (job[gi-1]),
				.right_job ('0),
				.gt        (gt[gi]),
				.job       (job[gi])
			);
		end else begin : g_mid
			sjfq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.used      (used[gi]),
				.left_gt   (gt[gi-1]),
				.left_job  (job[gi-1]),
				.right_job (job[gi+1]),
				.gt        (gt[gi]),
				.job       (job[gi])
			);
		end
	end

	// Advance the count on a successful insert, drop it on a removal.
	always_comb begin
		count_nxt = count_q;
		if (do_enq) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_deq) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			busy_q  <= accept;
		end
	end

	// Result register: hold the beat for its single strobe cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.occupancy <= OCC_W'(count_nxt);
			result_q.out_id    <= '0;
			result_q.out_burst <= '0;
			if (item.mode == MODE_ENQ) begin
				result_q.status <= is_full ? ST_FULL : ST_ENQUEUED;
			end else if (is_empty) begin
				result_q.status <= ST_EMPTY;
			end else begin
				result_q.status    <= ST_DEQUEUED;
				result_q.out_id    <= job[0].id;
				result_q.out_burst <= job[0].burst;
			end
		end
	end

	assign busy   = busy_q;
	assign done   = busy_q;
	assign result = result_q;

endmodule

// ----- rtl/core/sjfq_cell.sv -----
// ----------------------------------------------------------------------------
// sjfq_cell : one slot of the sorted job row
// Holds one job; on insert shifts right or takes the new job, on removal
// takes its right neighbour's job.
// ----------------------------------------------------------------------------
module sjfq_cell (
	input  logic              clk,
	input  sjfq_pkg::cell_ctl_t ctl,
	input  logic              used,
	input  logic              left_gt,
	input  sjfq_pkg::entry_t  left_job,
	input  sjfq_pkg::entry_t  right_job,
	output logic              gt,
	output sjfq_pkg::entry_t  job
);
	import sjfq_pkg::*;

	entry_t job_q;

	// Empty slots rank behind every job; equal bursts keep arrival order.
	assign gt  = !used || (job_q.burst > ctl.new_job.burst);
	assign job = job_q;

	always_ff @(posedge clk) begin
		if (ctl.deq) begin
			job_q <= right_job;
		end else if (ctl.enq && gt) begin
			job_q <= left_gt ? left_job : ctl.new_job;
		end
	end

endmodule

// ----- rtl/core/sjfq_checker.sv -----
// ----------------------------------------------------------------------------
// sjfq_checker : port-level checks for the shortest-job-first queue
// Watches command and result beats on the top-level ports.
// ----------------------------------------------------------------------------
module sjfq_checker #(
	parameter int DEPTH = sjfq_pkg::DEPTH_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input sjfq_pkg::item_t   item,
	input logic              done,
	input sjfq_pkg::result_t result
);
	import sjfq_pkg::*;

	localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

	// Every command beat yields a result beat in the next cycle.
	a_cmd_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("command beat without result beat");

	// A result beat only follows a command beat.
	a_result_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result beat without command beat");

	// Empty report carries zero fields and zero occupancy.
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |->
		(result.out_id == '0 && result.out_burst == '0 && result.occupancy == '0))
		else $error("empty result with non-zero fields");

	// Full report shows a full queue and zero fields.
	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |->
		(result.out_id == '0 && result.out_burst == '0 && result.occupancy == DEPTH_OCC))
		else $error("full result inconsistent");

	// A dequeue command yields a dequeued or an empty status.
	a_status_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode == MODE_DEQ) |=>
		(result.status == ST_DEQUEUED || result.status == ST_EMPTY))
		else $error("dequeue command with enqueue status");

endmodule

bind shortest_job_first_queue sjfq_checker #(.DEPTH(DEPTH)) u_sjfq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

// ----- tb/sjfq_checker.sv -----
// ----------------------------------------------------------------------------
// sjfq_scoreboard : result checker for the shortest-job-first queue
// Watches command and result beats and keeps its own copy of the held
// jobs. Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sjfq_scoreboard #(
	parameter int DEPTH = sjfq_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  sjfq_pkg::item_t   item,
	input  logic              done,
	input  sjfq_pkg::result_t result,
	output int                owed,
	output int                failures
);
	timeunit 1ns;
	timeprecision 1ps;

	import sjfq_pkg::*;

	entry_t  held_jobs[$];
	result_t owed_results[$];
	int      owed_count;
	int      mismatch_count = 0;

	assign owed     = owed_count;
	assign failures = mismatch_count;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: mismatch on %s, got %0h, want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Apply one command to the held jobs and return the result it gives.
	function automatic result_t sjf_outcome(input item_t cmd);
		result_t r;
		entry_t  job;
		int      pick;
		r = '0;
		if (cmd.mode == MODE_ENQ) begin
			if (held_jobs.size() >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				job = {cmd.job_id, cmd.burst_time};
				held_jobs.push_back(job);
				r.status = ST_ENQUEUED;
			end
		end else if (held_jobs.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			// strict less-than keeps the earliest arrival on a tie
			pick = 0;
			for (int i = 1; i < held_jobs.size(); i++)
				if (held_jobs[i].burst < held_jobs[pick].burst)
					pick = i;
			r.status    = ST_DEQUEUED;
			r.out_id    = held_jobs[pick].id;
			r.out_burst = held_jobs[pick].burst;
			held_jobs.delete(pick);
		end
		r.occupancy = OCC_W'(held_jobs.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			held_jobs.delete();
			owed_results.delete();
			owed_count <= 0;
		end else begin
			if (done) begin
				if (owed_results.size() == 0) begin
					report("result beat with nothing owed", 32'(result), 32'd0);
				end else begin
					want = owed_results.pop_front();
					if (result.status !== want.status)
						report("status", 32'(result.status), 32'(want.status));
					if (result.out_id !== want.out_id)
						report("out_id", 32'(result.out_id), 32'(want.out_id));
					if (result.out_burst !== want.out_burst)
						report("out_burst", 32'(result.out_burst), 32'(want.out_burst));
					if (result.occupancy !== want.occupancy)
						report("occupancy", 32'(result.occupancy), 32'(want.occupancy));
				end
			end
			if (start && !busy)
				owed_results.push_back(sjf_outcome(item));
			owed_count <= owed_results.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb : testbench top for the shortest-job-first queue
// Drives command beats in bursts with random gaps: a directed opening on
// the extremes, then random phases that fill, drain and churn the queue.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sjfq_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int RAND_BEATS = 550;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    done;
	result_t result;
	int      owed;
	int      failures;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	shortest_job_first_queue #(.DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	sjfq_scoreboard #(.DEPTH(DEPTH)) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.owed     (owed),
		.failures (failures)
	);

	// Present one command beat and hold it until the queue takes it.
	// Start is left high so that a following beat can go back to back.
	task automatic issue(input logic mode, input logic [ID_W-1:0] id,
			input logic [BURST_W-1:0] burst);
		item_t cmd;
		cmd.mode       = mode;
		cmd.job_id     = id;
		cmd.burst_time = burst;
		start <= 1'b1;
		item  <= cmd;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for the requested number of cycles; scramble the item bus so that
	// nothing is taken from it while start is low.
	task automatic idle(input int cycles);
		start <= 1'b0;
		item  <= item_t'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every owed result has come back. The first edge lets
	// the checker count the beat just taken.
	task automatic drain();
		idle(1);
		while (owed != 0) @(posedge clk);
	endtask

	// Burst times: a narrow band forces ties, the rest spans the full range.
	function automatic logic [BURST_W-1:0] pick_burst();
		case ($urandom_range(0, 5))
			0, 1:    return BURST_W'($urandom_range(0, 7));
			2:       return $urandom_range(0, 1) ? '1 : '0;
			default: return BURST_W'($urandom);
		endcase
	endfunction

	initial begin
		#1ms;
		$display("** shortest_job_first_queue: FAILED **");
		$finish;
	end

	initial begin
		int sent;
		int phase_len;
		int enq_pct;
		int burst_len;
		int gap;
		int phase_no;
		bit quiet;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed opening: empty, extremes, ties, full, then drain past empty.
		issue(MODE_DEQ, 8'hC3, 16'h1234);
		issue(MODE_ENQ, 8'hFF, 16'hFFFF);
		issue(MODE_ENQ, 8'h00, 16'h0000);
		issue(MODE_ENQ, 8'hA5, 16'h8000);
		idle(2);
		issue(MODE_ENQ, 8'h5A, 16'h0000);
		issue(MODE_ENQ, 8'h01, 16'hFFFF);
		issue(MODE_ENQ, 8'h02, 16'h0007);
		idle(1);
		issue(MODE_ENQ, 8'h03, 16'h0007);
		issue(MODE_ENQ, 8'h04, 16'h7FFF);
		issue(MODE_ENQ, 8'h77, 16'h0001);
		issue(MODE_ENQ, 8'h88, 16'hFFFE);
		drain();
		repeat (DEPTH) begin
			issue(MODE_DEQ, 8'(ID_W'($urandom)), BURST_W'($urandom));
			if ($urandom_range(0, 2) == 0)
				idle($urandom_range(1, 3));
		end
		issue(MODE_DEQ, 8'hFF, 16'hFFFF);
		issue(MODE_ENQ, 8'h42, 16'hFFFF);
		issue(MODE_DEQ, 8'h00, 16'h0000);
		drain();

		// Random phases: fill-heavy, drain-heavy and balanced mixes push the
		// queue through full and empty again and again.
		sent = 0;
		phase_no = 0;
		while (sent < RAND_BEATS) begin
			case (phase_no % 3)
				0:       enq_pct = 80;
				1:       enq_pct = 25;
				default: enq_pct = 55;
			endcase
			phase_len = $urandom_range(15, 50);
			quiet = ($urandom_range(0, 3) == 0);
			while (phase_len > 0 && sent < RAND_BEATS) begin
				burst_len = $urandom_range(1, 12);
				while (burst_len > 0 && phase_len > 0) begin
					issue(($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ,
						ID_W'($urandom), pick_burst());
					burst_len--;
					phase_len--;
					sent++;
				end
				gap = quiet ? 0 : $urandom_range(0, 6);
				if (gap != 0)
					idle(gap);
			end
			if (phase_no % 4 == 3)
				drain();
			phase_no++;
		end

		drain();
		repeat (4) @(posedge clk);
		if (failures == 0)
			$display("** shortest_job_first_queue: PASSED **");
		else
			$display("** shortest_job_first_queue: FAILED **");
		$finish;
	end

endmodule
